// File: hdl/beag_pkg.sv
// Shared types, constants and helpers for the broadcast element-wise address generator.
// No dependencies; every other file refers to this package by scoped names.
package beag_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int DIM_BITS  = 16;
  localparam int DATA_BITS = 32;

  localparam int PACKED_W  = 64;
  localparam int COUNT_W   = 64;
  localparam int LANE_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ADDR_W    = 2 * DIM_BITS + LANE_W;
  localparam int SPAN_W    = 2 * DIM_BITS;
  localparam int DIMS_W    = 3;
  localparam int OP_W      = 2;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 2;
  localparam int QP_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W      = $clog2(Q_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(DATA_BITS + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OP       = 3'd6;

  // commands
  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMBINE = 2'd2;

  // arithmetic operations
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_SHAPE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_IDLE      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DIV0      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]            cmd;
    logic signed [DATA_BITS-1:0] value_a;
    logic signed [DATA_BITS-1:0] value_b;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic [COUNT_W-1:0]          element_count;
    logic [COUNT_W-1:0]          element_index;
    logic [ADDR_W-1:0]           address_a;
    logic [ADDR_W-1:0]           address_b;
    logic signed [DATA_BITS-1:0] result_value;
    logic                        last;
  } out_word_t;

  typedef struct packed {
    logic [DIMS_W-1:0]   dims_a;
    logic [DIMS_W-1:0]   dims_b;
    logic [PACKED_W-1:0] shape_a_packed;
    logic [PACKED_W-1:0] shape_b_packed;
    logic [PACKED_W-1:0] stride_a_packed;
    logic [PACKED_W-1:0] stride_b_packed;
    logic [OP_W-1:0]     operation;
  } cfg_t;

  // work class decided at the front
  typedef enum logic [2:0] {
    K_START,
    K_STEP,
    K_ALU,
    K_DIV,
    K_DIV0,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [DATA_BITS-1:0]  value_a;
    logic [DATA_BITS-1:0]  value_b;
  } item_t;

  // one DIM_BITS lane of a packed shape or stride word; lanes past the word read zero
  function automatic logic [DIM_BITS-1:0] lane_of(input logic [PACKED_W-1:0] vec,
                                                  input logic [LANE_W-1:0]   idx);
    return DIM_BITS'(vec >> (idx * DIM_BITS));
  endfunction

endpackage

// File: hdl/beag_cfg.sv
// Configuration register file: shapes, strides, dimension counts and operation.
// Depends on beag_pkg.
module beag_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [beag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [beag_pkg::PACKED_W-1:0]   cfg_data,
  output beag_pkg::cfg_t                  cfg
);

  beag_pkg::cfg_t cfg_r;
  beag_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        beag_pkg::REG_DIMS_A:   cfg_nxt.dims_a          = cfg_data[beag_pkg::DIMS_W-1:0];
        beag_pkg::REG_DIMS_B:   cfg_nxt.dims_b          = cfg_data[beag_pkg::DIMS_W-1:0];
        beag_pkg::REG_SHAPE_A:  cfg_nxt.shape_a_packed  = cfg_data;
        beag_pkg::REG_SHAPE_B:  cfg_nxt.shape_b_packed  = cfg_data;
        beag_pkg::REG_STRIDE_A: cfg_nxt.stride_a_packed = cfg_data;
        beag_pkg::REG_STRIDE_B: cfg_nxt.stride_b_packed = cfg_data;
        beag_pkg::REG_OP:       cfg_nxt.operation       = cfg_data[beag_pkg::OP_W-1:0];
        default:                cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dims_a          <= beag_pkg::DIMS_W'(1);
      cfg_r.dims_b          <= beag_pkg::DIMS_W'(1);
      cfg_r.shape_a_packed  <= beag_pkg::PACKED_W'(1);
      cfg_r.shape_b_packed  <= beag_pkg::PACKED_W'(1);
      cfg_r.stride_a_packed <= '0;
      cfg_r.stride_b_packed <= '0;
      cfg_r.operation       <= beag_pkg::OP_ADD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hdl/beag_front.sv
// Front end: takes input words, classifies them and holds them in a short queue.
// Depends on beag_pkg.
module beag_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [beag_pkg::OP_W-1:0]   operation,
  input  logic                        push,
  input  beag_pkg::in_word_t          in_word,
  output logic                        full,
  input  logic                        take,
  output logic                        head_valid,
  output beag_pkg::item_t             head
);

  beag_pkg::item_t               q_r [beag_pkg::Q_DEPTH];
  logic [beag_pkg::QP_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [beag_pkg::QP_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [beag_pkg::QC_W-1:0]     count_r, count_nxt;
  beag_pkg::item_t               cls;
  logic                          wr_en;

  assign full       = (count_r == beag_pkg::QC_W'(beag_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign wr_en      = push && !full;

  // divide by zero is spotted here so the back end never starts the divider for it
  always_comb begin
    cls.value_a = in_word.value_a;
    cls.value_b = in_word.value_b;
    unique case (in_word.cmd)
      beag_pkg::CMD_START: cls.kind = beag_pkg::K_START;
      beag_pkg::CMD_STEP:  cls.kind = beag_pkg::K_STEP;
      beag_pkg::CMD_COMBINE: begin
        if (operation != beag_pkg::OP_DIV) begin
          cls.kind = beag_pkg::K_ALU;
        end else if (in_word.value_b == '0) begin
          cls.kind = beag_pkg::K_DIV0;
        end else begin
          cls.kind = beag_pkg::K_DIV;
        end
      end
      default: cls.kind = beag_pkg::K_BAD;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == beag_pkg::QP_W'(beag_pkg::Q_DEPTH - 1)) ? '0
                                                                        : wr_ptr_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = (rd_ptr_r == beag_pkg::QP_W'(beag_pkg::Q_DEPTH - 1)) ? '0
                                                                        : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + beag_pkg::QC_W'(wr_en) - beag_pkg::QC_W'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (count_r != '0))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == beag_pkg::QC_W'(beag_pkg::Q_DEPTH)) && !take |=> count_r == $past(count_r))
    else $error("queue count moved past depth");

endmodule

// File: hdl/beag_div.sv
// Iterative unsigned divider, one quotient bit per cycle (restoring).
// Depends on beag_pkg.
module beag_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [beag_pkg::DATA_BITS-1:0]  dividend,
  input  logic [beag_pkg::DATA_BITS-1:0]  divisor,
  output logic                            done,
  output logic [beag_pkg::DATA_BITS-1:0]  quotient
);

  localparam int W = beag_pkg::DATA_BITS;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [beag_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]                  rem_r, rem_nxt;
  logic [W-1:0]                  quo_r, quo_nxt;
  logic [W-1:0]                  dvs_r, dvs_nxt;
  logic [W:0]                    sh;
  logic [W:0]                    diff;
  logic                          qbit;

  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    sh   = {rem_r, quo_r[W-1]};
    diff = sh - {1'b0, dvs_r};
    qbit = !diff[W];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = beag_pkg::DIV_CNT_W'(W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[W-1:0] : sh[W-1:0];
      quo_nxt = {quo_r[W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == beag_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

// File: hdl/beag_back.sv
// Back end: start sequencer over the lanes, odometer with running address sums,
// arithmetic and result register. Depends on beag_pkg and beag_div.
module beag_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  beag_pkg::cfg_t       cfg,
  input  logic                 head_valid,
  input  beag_pkg::item_t      head,
  output logic                 take,
  output beag_pkg::out_word_t  out_word,
  output logic                 empty,
  input  logic                 pop
);

  localparam int MD = beag_pkg::MAX_DIMS;
  localparam int DB = beag_pkg::DIM_BITS;
  localparam int AW = beag_pkg::ADDR_W;
  localparam int SW = beag_pkg::SPAN_W;
  localparam int CW = beag_pkg::COUNT_W;
  localparam int DW = beag_pkg::DATA_BITS;
  localparam int LW = beag_pkg::LANE_W;
  localparam int CMP_W = beag_pkg::DIMS_W + LW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LANE = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] lane_r, lane_nxt;
  logic          fail_r, fail_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [AW-1:0] prefix_a_r, prefix_a_nxt, prefix_b_r, prefix_b_nxt;
  logic [SW-1:0] span_a_r, span_a_nxt, span_b_r, span_b_nxt;
  logic [DB-1:0] out_shape_r [MD];
  logic [DB-1:0] out_shape_nxt [MD];
  logic [AW-1:0] rewind_a_r [MD];
  logic [AW-1:0] rewind_a_nxt [MD];
  logic [AW-1:0] rewind_b_r [MD];
  logic [AW-1:0] rewind_b_nxt [MD];
  logic [DB-1:0] cnt_r [MD];
  logic [DB-1:0] cnt_nxt [MD];
  logic [CW-1:0] elem_r, elem_nxt;
  logic [AW-1:0] addr_a_r, addr_a_nxt, addr_b_r, addr_b_nxt;
  logic          active_r, active_nxt;
  logic          neg_r, neg_nxt;
  beag_pkg::out_word_t out_word_r, out_word_nxt, res_word;
  logic          out_valid_r, out_valid_nxt;

  // lane evaluation
  logic          in_a, in_b, lane_ok;
  logic [DB-1:0] sa, sb, ta, tb, so, so_m1, ea, eb;

  // odometer
  logic [DB-1:0] inc [MD];
  logic [DB-1:0] step_cnt [MD];
  logic          found;
  logic [LW-1:0] k_sel;
  logic          last_step;

  // arithmetic
  logic [DW-1:0] alu_res;
  logic [DW-1:0] mag_a, mag_b;
  logic          div_start, div_done;
  logic [DW-1:0] div_q;

  assign take     = (state_r == ST_IDLE) && head_valid && (!out_valid_r || pop);
  assign empty    = !out_valid_r;
  assign out_word = out_word_r;

  beag_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mag_a     = head.value_a[DW-1] ? (~head.value_a + 1'b1) : head.value_a;
  assign mag_b     = head.value_b[DW-1] ? (~head.value_b + 1'b1) : head.value_b;
  assign div_start = take && (head.kind == beag_pkg::K_DIV);

  always_comb begin
    unique case (cfg.operation)
      beag_pkg::OP_ADD: alu_res = head.value_a + head.value_b;
      beag_pkg::OP_SUB: alu_res = head.value_a - head.value_b;
      beag_pkg::OP_MUL: alu_res = head.value_a * head.value_b;
      default:          alu_res = '0;
    endcase
  end

  // one lane of the right-aligned shapes per cycle
  always_comb begin
    in_a    = CMP_W'(lane_r) < CMP_W'(cfg.dims_a);
    in_b    = CMP_W'(lane_r) < CMP_W'(cfg.dims_b);
    sa      = in_a ? beag_pkg::lane_of(cfg.shape_a_packed, lane_r)  : DB'(1);
    ta      = in_a ? beag_pkg::lane_of(cfg.stride_a_packed, lane_r) : '0;
    sb      = in_b ? beag_pkg::lane_of(cfg.shape_b_packed, lane_r)  : DB'(1);
    tb      = in_b ? beag_pkg::lane_of(cfg.stride_b_packed, lane_r) : '0;
    lane_ok = (sa == sb) || (sa == DB'(1)) || (sb == DB'(1));
    so      = (sa == DB'(1)) ? sb : sa;
    so_m1   = so - 1'b1;
    ea      = (sa == DB'(1)) ? '0 : ta;
    eb      = (sb == DB'(1)) ? '0 : tb;
  end

  // lowest dimension that does not wrap takes the carry
  always_comb begin
    found = 1'b0;
    k_sel = '0;
    for (int i = 0; i < MD; i++) begin
      inc[i] = cnt_r[i] + 1'b1;
      if (!found && (inc[i] < out_shape_r[i])) begin
        found = 1'b1;
        k_sel = LW'(i);
      end
    end
    for (int i = 0; i < MD; i++) begin
      if (!found || (LW'(i) < k_sel)) begin
        step_cnt[i] = '0;
      end else if (LW'(i) == k_sel) begin
        step_cnt[i] = inc[i];
      end else begin
        step_cnt[i] = cnt_r[i];
      end
    end
    last_step = ((elem_r + 1'b1) == total_r);
  end

  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    fail_nxt      = fail_r;
    total_nxt     = total_r;
    prefix_a_nxt  = prefix_a_r;
    prefix_b_nxt  = prefix_b_r;
    span_a_nxt    = span_a_r;
    span_b_nxt    = span_b_r;
    out_shape_nxt = out_shape_r;
    rewind_a_nxt  = rewind_a_r;
    rewind_b_nxt  = rewind_b_r;
    cnt_nxt       = cnt_r;
    elem_nxt      = elem_r;
    addr_a_nxt    = addr_a_r;
    addr_b_nxt    = addr_b_r;
    active_nxt    = active_r;
    neg_nxt       = neg_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !pop;
    res_word      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          unique case (head.kind)
            beag_pkg::K_START: begin
              state_nxt    = ST_LANE;
              lane_nxt     = '0;
              fail_nxt     = 1'b0;
              total_nxt    = CW'(1);
              prefix_a_nxt = '0;
              prefix_b_nxt = '0;
              span_a_nxt   = '0;
              span_b_nxt   = '0;
              elem_nxt     = '0;
              addr_a_nxt   = '0;
              addr_b_nxt   = '0;
              active_nxt   = 1'b0;
              for (int i = 0; i < MD; i++) begin
                cnt_nxt[i] = '0;
              end
            end
            beag_pkg::K_STEP: begin
              if (active_r) begin
                res_word.status        = beag_pkg::STAT_OK;
                res_word.element_index = elem_r;
                res_word.address_a     = addr_a_r;
                res_word.address_b     = addr_b_r;
                res_word.last          = last_step;
                elem_nxt               = elem_r + 1'b1;
                cnt_nxt                = step_cnt;
                addr_a_nxt             = addr_a_r + rewind_a_r[k_sel];
                addr_b_nxt             = addr_b_r + rewind_b_r[k_sel];
                if (last_step) begin
                  active_nxt = 1'b0;
                end
              end else begin
                res_word.status = beag_pkg::STAT_IDLE;
              end
              out_word_nxt  = res_word;
              out_valid_nxt = 1'b1;
            end
            beag_pkg::K_ALU: begin
              res_word.result_value = alu_res;
              out_word_nxt          = res_word;
              out_valid_nxt         = 1'b1;
            end
            beag_pkg::K_DIV: begin
              neg_nxt   = head.value_a[DW-1] ^ head.value_b[DW-1];
              state_nxt = ST_DIV;
            end
            beag_pkg::K_DIV0: begin
              res_word.status = beag_pkg::STAT_DIV0;
              out_word_nxt    = res_word;
              out_valid_nxt   = 1'b1;
            end
            default: begin
              res_word.status = beag_pkg::STAT_IDLE;
              out_word_nxt    = res_word;
              out_valid_nxt   = 1'b1;
            end
          endcase
        end
      end
      ST_LANE: begin
        fail_nxt              = fail_r || !lane_ok;
        out_shape_nxt[lane_r] = so;
        total_nxt             = total_r * CW'(so);
        // offset added when this lane takes the carry: its stride less the
        // distance run through the lanes below it
        rewind_a_nxt[lane_r]  = AW'(ea) - prefix_a_r - AW'(span_a_r);
        rewind_b_nxt[lane_r]  = AW'(eb) - prefix_b_r - AW'(span_b_r);
        prefix_a_nxt          = prefix_a_r + AW'(span_a_r);
        prefix_b_nxt          = prefix_b_r + AW'(span_b_r);
        span_a_nxt            = SW'(so_m1) * SW'(ea);
        span_b_nxt            = SW'(so_m1) * SW'(eb);
        if (lane_r == LW'(MD - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (fail_r) begin
          res_word.status = beag_pkg::STAT_BAD_SHAPE;
        end else begin
          res_word.status        = beag_pkg::STAT_OK;
          res_word.element_count = total_r;
        end
        active_nxt    = !fail_r && (total_r != '0);
        out_word_nxt  = res_word;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          res_word.result_value = neg_r ? (~div_q + 1'b1) : div_q;
          out_word_nxt          = res_word;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_r      <= lane_nxt;
    fail_r      <= fail_nxt;
    total_r     <= total_nxt;
    prefix_a_r  <= prefix_a_nxt;
    prefix_b_r  <= prefix_b_nxt;
    span_a_r    <= span_a_nxt;
    span_b_r    <= span_b_nxt;
    out_shape_r <= out_shape_nxt;
    rewind_a_r  <= rewind_a_nxt;
    rewind_b_r  <= rewind_b_nxt;
    cnt_r       <= cnt_nxt;
    elem_r      <= elem_nxt;
    addr_a_r    <= addr_a_nxt;
    addr_b_r    <= addr_b_nxt;
    neg_r       <= neg_nxt;
    out_word_r  <= out_word_nxt;
  end

  a_lane_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LANE) |-> !active_r)
    else $error("iteration live during shape set-up");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide wait");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (head.kind == beag_pkg::K_STEP) && active_r && last_step) |=> !active_r)
    else $error("iteration still live after final element");

endmodule

// File: hdl/broadcast_elementwise_address_gen_top.sv
// Broadcast element-wise address generator, NumPy-style, up to MAX_DIMS dimensions.
//
// Input words enter through push/full: a word is taken on a clock edge with push high
// and full low. Result words leave through empty/pop: the oldest result sits on out_word
// while empty is low and is taken on an edge with pop high. Registers are written on
// the cfg channel (cfg_ready is always high); write them only while the block is idle.
//
// Every input word gives exactly one result word, in order.
// Handling, per item once the back end picks it up from the front queue:
//   step, add/sub/multiply combine, divide by zero, unknown command: result registered on pickup
//   start: set-up on pickup, then one lane of the shapes at a time, then the report
//   divide: waits on the bit-serial divider, then registers the signed quotient
// From push, a word passes through the front queue and then the result register. Steps and plain combines
// stream at one word per cycle while results are taken; addresses come from an odometer
// whose carry lane picks a precomputed offset, so no multiplier sits in the step path.
// A two-entry queue parts the front from the back, and a single result register parts
// the back from the receiver: while results go untaken the back end holds and the queue
// fills, after which full rises. Reset (rst_n low at a clock edge) clears the queue, the
// result register and iteration, and loads the register reset values.
// Depends on beag_pkg, beag_cfg, beag_front, beag_div and beag_back.
module broadcast_elementwise_address_gen_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            push,
  input  beag_pkg::in_word_t              in_word,
  output logic                            full,
  // result words
  input  logic                            pop,
  output logic                            empty,
  output beag_pkg::out_word_t             out_word,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [beag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [beag_pkg::PACKED_W-1:0]   cfg_data
);

  beag_pkg::cfg_t  cfg;
  beag_pkg::item_t head;
  logic            head_valid;
  logic            take;

  beag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // classification and queueing
  beag_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .operation  (cfg.operation),
    .push       (push),
    .in_word    (in_word),
    .full       (full),
    .take       (take),
    .head_valid (head_valid),
    .head       (head)
  );

  // execution and result register
  beag_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .out_word   (out_word),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// File: sim/tb.sv
// Self-checking bench for broadcast_elementwise_address_gen_top: a queue-fed word driver,
// a result monitor and a predictor of start, step and combine behaviour.
// Depends on beag_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;

  // cmd value the block does not decode; must answer idle and leave state alone
  localparam logic [beag_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off to fill the block
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake of any kind
  localparam int ROUND_WORDS    = 20;    // words per random round, before the last run ends

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           push      = 1'b0;
  beag_pkg::in_word_t             in_word   = '0;
  logic                           full;
  logic                           pop       = 1'b0;
  logic                           empty;
  beag_pkg::out_word_t            out_word;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [beag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [beag_pkg::PACKED_W-1:0]  cfg_data  = '0;

  broadcast_elementwise_address_gen_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_word   (in_word),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers and of the odometer
  // ---------------------------------------------------------------------------
  beag_pkg::cfg_t                regs;
  logic [beag_pkg::DIM_BITS-1:0] odo    [beag_pkg::MAX_DIMS];  // per-lane position counters
  logic [beag_pkg::DIM_BITS-1:0] span   [beag_pkg::MAX_DIMS];  // latched output shape
  logic [beag_pkg::DIM_BITS-1:0] step_a [beag_pkg::MAX_DIMS];  // effective strides
  logic [beag_pkg::DIM_BITS-1:0] step_b [beag_pkg::MAX_DIMS];
  logic [beag_pkg::COUNT_W-1:0]  elem_no;
  logic [beag_pkg::COUNT_W-1:0]  elem_total;
  logic                          iterating;

  beag_pkg::in_word_t  words_waiting [$];  // words not yet offered to the block
  beag_pkg::out_word_t results_due   [$];  // expected result words, oldest first

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatches    = 0;
  int  idle_cycles   = 0;
  int  hold_cnt      = 0;
  logic hold_trig    = 1'b0;
  logic hold_done    = 1'b0;
  beag_pkg::out_word_t head;

  // Works out the result word for one accepted input word and advances the state.
  function automatic beag_pkg::out_word_t compute_result(input beag_pkg::in_word_t w);
    beag_pkg::out_word_t           r;
    int                            i;
    int unsigned                   na, nb;
    logic [beag_pkg::DIM_BITS-1:0] sa, sb, ta, tb, so;
    logic [beag_pkg::DIM_BITS-1:0] shp [beag_pkg::MAX_DIMS];
    logic [beag_pkg::DIM_BITS-1:0] sta [beag_pkg::MAX_DIMS];
    logic [beag_pkg::DIM_BITS-1:0] stb [beag_pkg::MAX_DIMS];
    logic [beag_pkg::COUNT_W-1:0]  total, acc_a, acc_b;
    logic signed [beag_pkg::DATA_BITS-1:0] qa, qb;
    logic                          bad, last_one, carry;
    r = '0;
    case (w.cmd)
      beag_pkg::CMD_START: begin
        // oversized dims saturate; missing outer lanes pad to size 1, stride 0
        na = (regs.dims_a > beag_pkg::MAX_DIMS) ? beag_pkg::MAX_DIMS : regs.dims_a;
        nb = (regs.dims_b > beag_pkg::MAX_DIMS) ? beag_pkg::MAX_DIMS : regs.dims_b;
        total = 64'd1;
        bad = 1'b0;
        for (i = 0; i < beag_pkg::MAX_DIMS; i++) begin
          sa = 16'd1; sb = 16'd1; ta = '0; tb = '0;
          if (i < na) begin
            sa = regs.shape_a_packed[i*beag_pkg::DIM_BITS +: beag_pkg::DIM_BITS];
            ta = regs.stride_a_packed[i*beag_pkg::DIM_BITS +: beag_pkg::DIM_BITS];
          end
          if (i < nb) begin
            sb = regs.shape_b_packed[i*beag_pkg::DIM_BITS +: beag_pkg::DIM_BITS];
            tb = regs.stride_b_packed[i*beag_pkg::DIM_BITS +: beag_pkg::DIM_BITS];
          end
          if (!(sa == sb || sa == 16'd1 || sb == 16'd1)) bad = 1'b1;
          so = (sa == 16'd1) ? sb : sa;
          shp[i] = so;
          sta[i] = (sa == 16'd1) ? '0 : ta;
          stb[i] = (sb == 16'd1) ? '0 : tb;
          total = total * 64'(so);
        end
        for (i = 0; i < beag_pkg::MAX_DIMS; i++) begin
          odo[i] = '0; span[i] = '0; step_a[i] = '0; step_b[i] = '0;
        end
        elem_no = '0; elem_total = '0; iterating = 1'b0;
        if (bad) begin
          r.status = beag_pkg::STAT_BAD_SHAPE;
        end else begin
          for (i = 0; i < beag_pkg::MAX_DIMS; i++) begin
            span[i] = shp[i]; step_a[i] = sta[i]; step_b[i] = stb[i];
          end
          elem_total = total;
          iterating = (total != 0);   // zero-element shapes report ok but never iterate
          r.status = beag_pkg::STAT_OK;
          r.element_count = total;
        end
      end
      beag_pkg::CMD_STEP: begin
        if (!iterating) begin
          r.status = beag_pkg::STAT_IDLE;
        end else begin
          acc_a = '0; acc_b = '0;
          for (i = 0; i < beag_pkg::MAX_DIMS; i++) begin
            acc_a = acc_a + 64'(odo[i]) * 64'(step_a[i]);
            acc_b = acc_b + 64'(odo[i]) * 64'(step_b[i]);
          end
          last_one = (elem_no + 64'd1) == elem_total;
          r.status = beag_pkg::STAT_OK;
          r.element_index = elem_no;
          r.address_a = acc_a[beag_pkg::ADDR_W-1:0];
          r.address_b = acc_b[beag_pkg::ADDR_W-1:0];
          r.last = last_one;
          // odometer, innermost lane first
          carry = 1'b1;
          for (i = 0; i < beag_pkg::MAX_DIMS; i++) begin
            if (carry) begin
              odo[i] = odo[i] + 1'b1;
              if (odo[i] < span[i]) carry = 1'b0;
              else odo[i] = '0;
            end
          end
          elem_no = elem_no + 64'd1;
          if (last_one) iterating = 1'b0;
        end
      end
      beag_pkg::CMD_COMBINE: begin
        qa = w.value_a;
        qb = w.value_b;
        case (regs.operation)
          beag_pkg::OP_ADD: r.result_value = qa + qb;
          beag_pkg::OP_SUB: r.result_value = qa - qb;
          beag_pkg::OP_MUL: r.result_value = qa * qb;
          default: begin
            if (qb == 0) begin
              r.status = beag_pkg::STAT_DIV0;
            end else if (qa == 32'sh8000_0000 && qb == -32'sd1) begin
              r.result_value = qa;   // most negative over minus one wraps to itself
            end else begin
              r.result_value = qa / qb;
            end
          end
        endcase
      end
      default: r.status = beag_pkg::STAT_IDLE;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Word driver: offers queued words, predicts each one on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) results_due.push_back(compute_result(in_word));
      // slot is free once the current word has gone or none was offered
      if (!push || !full) begin
        if (words_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= words_waiting.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares each taken word with the oldest expectation.
  // Holds pop low once hold_trig rises, until hold_cnt reaches HOLD_CYCLES, so the block backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $error("result word taken with nothing expected");
          mismatches++;
        end else begin
          head = results_due.pop_front();
          check_field("status",        64'(head.status),        64'(out_word.status));
          check_field("element_count", head.element_count,      out_word.element_count);
          check_field("element_index", head.element_index,      out_word.element_index);
          check_field("address_a",     64'(head.address_a),     64'(out_word.address_a));
          check_field("address_b",     64'(head.address_b),     64'(out_word.address_b));
          check_field("result_value",  64'(head.result_value),  64'(out_word.result_value));
          check_field("last",          64'(head.last),          64'(out_word.last));
        end
      end
      if (hold_trig && !hold_done) begin
        pop <= 1'b0;
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES) hold_done <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send(input logic [beag_pkg::CMD_W-1:0] c,
                      input logic [beag_pkg::DATA_BITS-1:0] a,
                      input logic [beag_pkg::DATA_BITS-1:0] b);
    beag_pkg::in_word_t w;
    w.cmd = c;
    w.value_a = a;
    w.value_b = b;
    words_waiting.push_back(w);
  endtask

  // register write; the predictor copy changes at the handshake edge
  task automatic write_reg(input logic [beag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [beag_pkg::PACKED_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      beag_pkg::REG_DIMS_A:   regs.dims_a          = val[beag_pkg::DIMS_W-1:0];
      beag_pkg::REG_DIMS_B:   regs.dims_b          = val[beag_pkg::DIMS_W-1:0];
      beag_pkg::REG_SHAPE_A:  regs.shape_a_packed  = val;
      beag_pkg::REG_SHAPE_B:  regs.shape_b_packed  = val;
      beag_pkg::REG_STRIDE_A: regs.stride_a_packed = val;
      beag_pkg::REG_STRIDE_B: regs.stride_b_packed = val;
      beag_pkg::REG_OP:       regs.operation       = val[beag_pkg::OP_W-1:0];
      default: ;
    endcase
  endtask

  // every word answers, so an empty expectation queue means the block is idle
  task automatic settle();
    while (words_waiting.size() != 0 || push || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly small sizes so runs finish; ones for broadcast, a few zeros and big lanes
  function automatic logic [beag_pkg::DIM_BITS-1:0] rand_lane();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3)  return beag_pkg::DIM_BITS'($urandom);
    if (p < 5)  return '1;
    if (p < 10) return '0;
    if (p < 35) return 16'd1;
    return beag_pkg::DIM_BITS'($urandom_range(2, 4));
  endfunction

  function automatic logic [beag_pkg::DATA_BITS-1:0] rand_val();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      4: return $urandom_range(1, 9);
      default: return $urandom;
    endcase
  endfunction

  // One register setting and a burst of words. Variant 0 is the all-ones extreme,
  // variant 1 the all-zero one, the rest random with b mostly matching or broadcasting.
  task automatic random_round(input int unsigned variant);
    logic [beag_pkg::PACKED_W-1:0] sha, shb;
    logic [beag_pkg::DIM_BITS-1:0] la;
    int unsigned                   made, run, l, pick;
    sha = '0;
    shb = '0;
    for (l = 0; l < beag_pkg::MAX_DIMS; l++) begin
      la = rand_lane();
      pick = $urandom_range(99);
      sha[l*beag_pkg::DIM_BITS +: beag_pkg::DIM_BITS] = la;
      shb[l*beag_pkg::DIM_BITS +: beag_pkg::DIM_BITS] =
        (pick < 50) ? la : (pick < 80) ? 16'd1 : rand_lane();
    end
    case (variant)
      0: begin
        write_reg(beag_pkg::REG_DIMS_A, 64'd7);
        write_reg(beag_pkg::REG_DIMS_B, 64'd4);
        write_reg(beag_pkg::REG_SHAPE_A, '1);
        write_reg(beag_pkg::REG_SHAPE_B, '1);
        write_reg(beag_pkg::REG_STRIDE_A, '1);
        write_reg(beag_pkg::REG_STRIDE_B, '1);
      end
      1: begin
        write_reg(beag_pkg::REG_DIMS_A, '0);
        write_reg(beag_pkg::REG_DIMS_B, '0);
        write_reg(beag_pkg::REG_SHAPE_A, '0);
        write_reg(beag_pkg::REG_SHAPE_B, '0);
        write_reg(beag_pkg::REG_STRIDE_A, '0);
        write_reg(beag_pkg::REG_STRIDE_B, '0);
      end
      default: begin
        write_reg(beag_pkg::REG_DIMS_A, 64'($urandom_range(0, 7)));
        write_reg(beag_pkg::REG_DIMS_B, 64'($urandom_range(0, 7)));
        write_reg(beag_pkg::REG_SHAPE_A, sha);
        write_reg(beag_pkg::REG_SHAPE_B, shb);
        write_reg(beag_pkg::REG_STRIDE_A, {$urandom, $urandom});
        write_reg(beag_pkg::REG_STRIDE_B, {$urandom, $urandom});
      end
    endcase
    write_reg(beag_pkg::REG_OP, 64'($urandom_range(0, 3)));
    made = 0;
    while (made < ROUND_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        // well-formed run: start, then steps with the odd combine mixed in
        send(beag_pkg::CMD_START, rand_val(), rand_val());
        run = $urandom_range(1, 40);
        repeat (run) begin
          if ($urandom_range(9) == 0) send(beag_pkg::CMD_COMBINE, rand_val(), rand_val());
          else send(beag_pkg::CMD_STEP, rand_val(), rand_val());
        end
        made += run + 1;
      end else if (pick < 85) begin
        send(beag_pkg::CMD_COMBINE, rand_val(), rand_val());
        made++;
      end else if (pick < 93) begin
        send(beag_pkg::CMD_STEP, rand_val(), rand_val());
        made++;
      end else begin
        send(CMD_UNKNOWN, rand_val(), rand_val());
        made++;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rnd;
    // register and iteration reset values
    regs.dims_a = 3'd1;
    regs.dims_b = 3'd1;
    regs.shape_a_packed = 64'd1;
    regs.shape_b_packed = 64'd1;
    regs.stride_a_packed = '0;
    regs.stride_b_packed = '0;
    regs.operation = beag_pkg::OP_ADD;
    for (int i = 0; i < beag_pkg::MAX_DIMS; i++) begin
      odo[i] = '0; span[i] = '0; step_a[i] = '0; step_b[i] = '0;
    end
    elem_no = '0;
    elem_total = '0;
    iterating = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, single-element shape
    send(beag_pkg::CMD_STEP, '0, '0);                        // step before any start
    send(CMD_UNKNOWN, 32'h1234_5678, 32'h9ABC_DEF0);
    send(beag_pkg::CMD_COMBINE, 32'h7FFF_FFFF, 32'd1);       // add wraps to most negative
    send(beag_pkg::CMD_COMBINE, 32'h8000_0000, '1);          // and back again
    send(beag_pkg::CMD_START, '0, '0);
    send(beag_pkg::CMD_STEP, '0, '0);                        // only element, last set
    send(beag_pkg::CMD_STEP, '0, '0);                        // step after the last element
    settle();

    // too many dims on a, scalar b; size-one lanes of a must drop their strides
    write_reg(beag_pkg::REG_DIMS_A, 64'd7);
    write_reg(beag_pkg::REG_DIMS_B, '0);
    write_reg(beag_pkg::REG_SHAPE_A, 64'h0002_0001_0001_0002);
    write_reg(beag_pkg::REG_STRIDE_A, 64'hFFFF_1234_5678_FFFF);
    write_reg(beag_pkg::REG_SHAPE_B, '1);
    write_reg(beag_pkg::REG_STRIDE_B, '1);
    write_reg(beag_pkg::REG_OP, 64'(beag_pkg::OP_SUB));
    send(beag_pkg::CMD_START, '0, '0);
    send(beag_pkg::CMD_STEP, '0, '0);
    send(beag_pkg::CMD_COMBINE, 32'h8000_0000, 32'd1);       // combine mid-iteration
    repeat (3) send(beag_pkg::CMD_STEP, '0, '0);
    send(beag_pkg::CMD_STEP, '0, '0);
    settle();

    // incompatible shapes and the divide corners
    write_reg(beag_pkg::REG_OP, 64'(beag_pkg::OP_DIV));
    write_reg(beag_pkg::REG_DIMS_A, 64'd2);
    write_reg(beag_pkg::REG_DIMS_B, 64'd2);
    write_reg(beag_pkg::REG_SHAPE_A, 64'h0000_0000_0004_0003);
    write_reg(beag_pkg::REG_SHAPE_B, 64'h0000_0000_0004_0002);
    send(beag_pkg::CMD_START, '0, '0);
    send(beag_pkg::CMD_STEP, '0, '0);                        // step after a failed start
    send(beag_pkg::CMD_COMBINE, 32'd5, '0);                  // divide by zero
    send(beag_pkg::CMD_COMBINE, 32'h8000_0000, '1);          // most negative over minus one
    send(beag_pkg::CMD_COMBINE, -32'sd7, 32'd2);             // truncates toward zero
    settle();

    // zero-sized lane against size one: ok, count zero, no iteration
    write_reg(beag_pkg::REG_OP, 64'(beag_pkg::OP_MUL));
    write_reg(beag_pkg::REG_SHAPE_A, 64'h0000_0000_0004_0000);
    write_reg(beag_pkg::REG_SHAPE_B, 64'h0000_0000_0004_0001);
    send(beag_pkg::CMD_START, '0, '0);
    send(beag_pkg::CMD_STEP, '0, '0);
    send(beag_pkg::CMD_COMBINE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    settle();

    // random part: receiver-heavy idling, then sender-heavy, then none
    send_idle_pct = 30;
    recv_idle_pct = 68;
    for (rnd = 0; rnd < 6; rnd++) random_round(rnd);
    send_idle_pct = 68;
    recv_idle_pct = 30;
    for (rnd = 0; rnd < 6; rnd++) random_round(rnd);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (rnd = 0; rnd < 6; rnd++) begin
      if (rnd == 2) begin
        @(posedge clk);
        hold_trig <= 1'b1;   // receiver backs off while the driver keeps offering
      end
      random_round(rnd);
    end

    settle();
    repeat (50) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d result words never arrived", results_due.size());
      mismatches++;
    end
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
